// ----- rtl/lphs_pkg.sv -----
// Shared constants and types for the linear probing hash set.
package lphs_pkg;

	localparam int TABLE_SIZE = 128;
	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int KEY_W = 31;
	localparam int OP_W = 2;
	localparam int S_DATA_W = ((OP_W + KEY_W + 7) / 8) * 8;
	localparam int M_DATA_W = 8;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/linear_probe_hash_set.sv -----
// Top level of the linear probing hash set: probe sequencer, key memory, used marks.
// Each item is one beat in and one beat out; an unused opcode goes straight to the result,
// others probe with one key memory read per step, for up to TABLE_SIZE steps.
// Throughput: one item at a time; the next beat is taken the cycle after a result is
// handed to the output register, which holds it until taken.
// Reset: arst_n clears all used marks and control at once; key memory is not cleared.
module linear_probe_hash_set
	import lphs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [1:0] operation, [32:2] key
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // [0] hit
);

	state_t state_q, state_d;
	op_t op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] addr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] found_q;
	logic hit_q;

	logic [KEY_W-1:0] key_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] used_q;

	logic rd_vld_s1;
	logic rd_used_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [KEY_W-1:0] rd_key_s1;

	logic m_tvalid_q;
	logic m_hit_q;

	logic [OP_W-1:0] in_op;
	logic [KEY_W-1:0] in_key;
	logic accept;
	logic rd_en;
	logic hit_now;
	logic commit;
	logic mem_we;

	assign in_op = s_tdata[OP_W-1:0];
	assign in_key = s_tdata[OP_W+KEY_W-1:OP_W];
	assign accept = s_tvalid && s_tready;
	assign mem_we = commit && hit_q && (op_q == OP_INSERT);

	always_comb begin
		if (op_q == OP_INSERT) begin
			hit_now = rd_vld_s1 && !rd_used_s1;
		end else begin
			hit_now = rd_vld_s1 && rd_used_s1 && (rd_key_s1 == key_q);
		end
	end

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		rd_en = 1'b0;
		commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op inside {OP_INSERT, OP_SEARCH, OP_DELETE}) begin
						state_d = ST_PROBE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PROBE: begin
				rd_en = (cnt_q != CNT_W'(TABLE_SIZE));
				if (hit_now) begin
					state_d = ST_DONE;
				end else if (!rd_en && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			used_q <= '0;
		end else begin
			rd_vld_s1 <= rd_en && !hit_now;
			if (accept) begin
				hit_q <= 1'b0;
			end else if (state_q == ST_PROBE && hit_now) begin
				hit_q <= 1'b1;
			end
			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (commit && hit_q) begin
				if (op_q == OP_INSERT) begin
					used_q[found_q] <= 1'b1;
				end else if (op_q == OP_DELETE) begin
					used_q[found_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(in_op);
			key_q <= in_key;
			addr_q <= in_key[IDX_W-1:0];
			cnt_q <= '0;
		end else if (rd_en) begin
			addr_q <= addr_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (rd_en) begin
			rd_idx_s1 <= addr_q;
			rd_used_s1 <= used_q[addr_q];
		end
		if (state_q == ST_PROBE && hit_now) begin
			found_q <= rd_idx_s1;
		end
		if (commit) begin
			m_hit_q <= hit_q;
		end
	end

	// key memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[found_q] <= key_q;
		end
		if (rd_en) begin
			rd_key_s1 <= key_mem[addr_q];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(M_DATA_W-1){1'b0}}, m_hit_q};

endmodule

// ----- rtl/lphs_checker.sv -----
// Port-level checker for the linear probing hash set, with its bind.
module lphs_checker
	import lphs_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// held result beat keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// busy after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// a new result only comes out of a busy block
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without an item in work");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_DATA_W-1:1] == '0)
		else $error("result padding not zero");

endmodule

bind linear_probe_hash_set lphs_checker u_lphs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
